>>> src/tmv_pkg.sv
// Package for the ternary matrix-vector engine: sizes, derived widths,
// request, status and config codes, trit codes, sequencer state type.
// No dependencies.
`default_nettype none

package tmv_pkg;

  // Storage capacity
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 64;
  localparam int WEIGHT_CAP  = MAX_ROWS * MAX_COLUMNS;

  // Index widths for the stores and the walk counters
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WIDX_W = (WEIGHT_CAP > 1) ? $clog2(WEIGHT_CAP) : 1;

  // Effective sizes hold 1..MAX, counts saturate at MAX+1
  localparam int ERW    = $clog2(MAX_ROWS + 1);
  localparam int ECW    = $clog2(MAX_COLUMNS + 1);
  localparam int WCNT_W = $clog2(WEIGHT_CAP + 2);
  localparam int ACNT_W = $clog2(MAX_COLUMNS + 2);

  // Fixed field widths
  localparam int ACTION_W   = 2;
  localparam int VAL_W      = 16;
  localparam int MAG_W      = 15;
  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int ROW_OUT_W  = 4;
  localparam int SUM_W      = 22;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = VAL_W + 1;

  // Accumulator: wide enough for MAX_COLUMNS clamped terms and the
  // saturation limits of the result field
  localparam int ACC_RAW_W = PROD_W + COL_W;
  localparam int ACC_W     = (ACC_RAW_W > SUM_W + 1) ? ACC_RAW_W : SUM_W + 1;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_LOAD_WEIGHT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_ACT    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN         = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR       = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WEIGHT_MISM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ACT_MISM    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

  // Configuration reset values
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 5'd16;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET      = 7'd64;
  localparam logic [MAG_W-1:0]      CLAMP_RESET     = 15'd256;
  localparam logic [MAG_W-1:0]      THRESHOLD_RESET = 15'd51;

  // Trit codes as stored
  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_POS  = 2'b01;
  localparam logic [1:0] TRIT_NEG  = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

>>> src/ternary_matvec_engine_core.sv
// Ternary-weight matrix-vector engine: trit and activation stores, run
// sequencer, clamp/accumulate pipeline and result register.
// Depends on tmv_pkg.
`default_nettype none

// Load and clear requests are taken one per cycle while idle and give no result. A run
// stalls the request side through a check state, one walk step per matrix entry (one
// read of each store) and a drain state. A count mismatch ends the run at the check.
// Row sums leave in row order; an error result leaves from the check state. A stalled
// result freezes the walk. Reset (rst, synchronous) clears counts, walk counters,
// sequencer and valid flags and restores the configuration registers; stores keep data.
module ternary_matvec_engine_core
  import tmv_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic [ACTION_W-1:0]          action,
  input  wire logic signed [VAL_W-1:0]      value,
  // result channel
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic [ROW_OUT_W-1:0]              row_index,
  output logic signed [SUM_W-1:0]           row_sum,
  output logic [STATUS_W-1:0]               status,
  output logic                              last,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam logic signed [ACC_W-1:0] SUM_MAX_A = ACC_W'((1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SUM_MIN_A = -ACC_W'(1 <<< (SUM_W - 1));

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [COLS_CFG_W-1:0] cols_cfg;
  logic [MAG_W-1:0]      clamp_cfg;
  logic [MAG_W-1:0]      thresh_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg   <= ROWS_RESET;
      cols_cfg   <= COLS_RESET;
      clamp_cfg  <= CLAMP_RESET;
      thresh_cfg <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:      rows_cfg   <= cfg_data[ROWS_CFG_W-1:0];
        CFG_COLUMNS:   cols_cfg   <= cfg_data[COLS_CFG_W-1:0];
        CFG_CLAMP:     clamp_cfg  <= cfg_data[MAG_W-1:0];
        CFG_THRESHOLD: thresh_cfg <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize acts as the capacity
  logic [ERW-1:0] eff_rows;
  logic [ECW-1:0] eff_cols;

  always_comb begin
    if (rows_cfg == '0) begin
      eff_rows = ERW'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = ERW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      eff_cols = ECW'(1);
    end else if (int'(cols_cfg) > MAX_COLUMNS) begin
      eff_cols = ECW'(MAX_COLUMNS);
    end else begin
      eff_cols = ECW'(cols_cfg);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and sequencer control
  // ---------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic item_acc;
  logic adv;          // pipeline may move: result register free or leaving
  logic issue;        // one walk step reads both stores
  logic err_load;     // count mismatch result goes out
  logic final_load;   // last row sum goes out

  logic [STATUS_W-1:0] run_err;
  logic [ERW-1:0]      run_rows;
  logic [ECW-1:0]      run_cols;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [WIDX_W-1:0]   widx;
  logic                col_last;
  logic                row_last;

  logic                p1_valid, p1_first, p1_last_col, p1_last_row;
  logic [ROW_W-1:0]    p1_row;
  logic                p2_valid, p2_first, p2_last_col, p2_last_row;
  logic [ROW_W-1:0]    p2_row;
  logic signed [PROD_W-1:0] p2_prod;

  assign item_acc = item_valid && !item_stall;
  assign adv      = !(result_valid && result_stall);
  assign col_last = (ECW'(col) + ECW'(1)) == run_cols;
  assign row_last = (ERW'(row) + ERW'(1)) == run_rows;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_acc && action == ACT_RUN) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (run_err != STATUS_OK) begin
          if (adv) state_next = ST_IDLE;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue && col_last && row_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (final_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    issue      = (state == ST_WALK) && adv;
    err_load   = (state == ST_CHECK) && (run_err != STATUS_OK) && adv;
    final_load = adv && p2_valid && p2_last_col && p2_last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Counts and run set-up
  // ---------------------------------------------------------------------
  logic [WCNT_W-1:0] wcount;
  logic [ACNT_W-1:0] acount;
  logic [ERW+ECW-1:0] weight_need;
  logic weight_mism;
  logic act_mism;

  assign weight_need = (ERW+ECW)'(eff_rows) * (ERW+ECW)'(eff_cols);
  assign weight_mism = (ERW+ECW+WCNT_W)'(wcount) != (ERW+ECW+WCNT_W)'(weight_need);
  assign act_mism    = (ACNT_W+ECW)'(acount) != (ACNT_W+ECW)'(eff_cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      wcount <= '0;
      acount <= '0;
    end else if (item_acc) begin
      case (action)
        ACT_LOAD_WEIGHT: begin
          if (wcount <= WCNT_W'(WEIGHT_CAP)) wcount <= wcount + WCNT_W'(1);
        end
        ACT_LOAD_ACT: begin
          if (acount <= ACNT_W'(MAX_COLUMNS)) acount <= acount + ACNT_W'(1);
        end
        ACT_RUN:   acount <= '0;
        ACT_CLEAR: wcount <= '0;
        default: ;
      endcase
    end
  end

  // Sizes and the check outcome are captured with the run request
  always_ff @(posedge clk) begin
    if (item_acc && action == ACT_RUN) begin
      run_rows <= eff_rows;
      run_cols <= eff_cols;
      if (weight_mism) begin
        run_err <= STATUS_WEIGHT_MISM;
      end else if (act_mism) begin
        run_err <= STATUS_ACT_MISM;
      end else begin
        run_err <= STATUS_OK;
      end
    end
  end

  // Walk counters; the linear index replaces row*cols+col
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      widx <= '0;
    end else if (item_acc && action == ACT_RUN) begin
      col  <= '0;
      row  <= '0;
      widx <= '0;
    end else if (issue) begin
      widx <= widx + WIDX_W'(1);
      if (col_last) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stores. Writes only happen in idle; the read registers load whenever the pipeline
  // may move, but only reads issued during a walk are used, never overlapping a write.
  // ---------------------------------------------------------------------
  logic [1:0]             trit_mem [WEIGHT_CAP];
  logic [VAL_W-1:0]       act_mem  [MAX_COLUMNS];
  logic [1:0]             trit_rd;
  logic signed [VAL_W-1:0] act_rd;

  logic signed [PROD_W-1:0] w_ext;
  logic signed [PROD_W-1:0] w_mag;
  logic [1:0]               trit_in;
  logic                     t_we;
  logic                     a_we;

  // Quantise on arrival
  always_comb begin
    w_ext = PROD_W'(value);
    w_mag = value[VAL_W-1] ? -w_ext : w_ext;
    if (w_mag < $signed({2'b00, thresh_cfg})) begin
      trit_in = TRIT_ZERO;
    end else if (value[VAL_W-1]) begin
      trit_in = TRIT_NEG;
    end else begin
      trit_in = TRIT_POS;
    end
  end

  assign t_we = item_acc && action == ACT_LOAD_WEIGHT && wcount < WCNT_W'(WEIGHT_CAP);
  assign a_we = item_acc && action == ACT_LOAD_ACT && acount < ACNT_W'(MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (t_we) trit_mem[wcount[WIDX_W-1:0]] <= trit_in;
    if (adv)  trit_rd <= trit_mem[widx];
  end

  always_ff @(posedge clk) begin
    if (a_we) act_mem[acount[COL_W-1:0]] <= value;
    if (adv)  act_rd <= act_mem[col];
  end

  // ---------------------------------------------------------------------
  // Pipeline: p1 meets the store read data, p2 holds the clamped term
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_first    <= (col == '0);
      p1_last_col <= col_last;
      p1_last_row <= row_last;
      p1_row      <= row;
    end
  end

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] c_ext;
  logic signed [PROD_W-1:0] a_clamped;
  logic signed [PROD_W-1:0] term;

  always_comb begin
    a_ext = PROD_W'(act_rd);
    c_ext = $signed({2'b00, clamp_cfg});
    if (a_ext > c_ext) begin
      a_clamped = c_ext;
    end else if (a_ext < -c_ext) begin
      a_clamped = -c_ext;
    end else begin
      a_clamped = a_ext;
    end
    case (trit_rd)
      TRIT_POS: term = a_clamped;
      TRIT_NEG: term = -a_clamped;
      default:  term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_prod     <= term;
      p2_first    <= p1_first;
      p2_last_col <= p1_last_col;
      p2_last_row <= p1_last_row;
      p2_row      <= p1_row;
    end
  end

  // Row accumulator; the row's final sum goes straight to the result
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum_full;
  logic signed [ACC_W-1:0] sum_sat;

  always_comb begin
    sum_full = (p2_first ? ACC_W'(0) : acc) + ACC_W'(p2_prod);
    if (sum_full > SUM_MAX_A) begin
      sum_sat = SUM_MAX_A;
    end else if (sum_full < SUM_MIN_A) begin
      sum_sat = SUM_MIN_A;
    end else begin
      sum_sat = sum_full;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p2_valid) acc <= sum_full;
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic row_load;
  assign row_load = adv && p2_valid && p2_last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (row_load || err_load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      row_index <= ROW_OUT_W'(p2_row);
      row_sum   <= sum_sat[SUM_W-1:0];
      status    <= STATUS_OK;
      last      <= p2_last_row;
    end else if (err_load) begin
      row_index <= '0;
      row_sum   <= '0;
      status    <= run_err;
      last      <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_run_clears_acount : assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && action == ACT_RUN) |=> (acount == '0))
    else $error("activation count not cleared by run");

  a_error_shape : assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != STATUS_OK) |->
      (last && row_index == '0 && row_sum == '0))
    else $error("error result malformed");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!p1_valid && !p2_valid))
    else $error("pipeline busy while idle");

  a_no_double_load : assert property (@(posedge clk) disable iff (rst)
    !(row_load && err_load))
    else $error("row and error result in the same cycle");

  a_wcount_bound : assert property (@(posedge clk) disable iff (rst)
    (wcount <= WCNT_W'(WEIGHT_CAP + 1)))
    else $error("weight count past saturation");

endmodule

`default_nettype wire
